@@ rtl/core/fwzd_pkg.sv @@
// Package for the force window zero detector: widths, register indexes and
// shared types. No dependencies.
package fwzd_pkg;

    localparam int WINDOW_MAX  = 512;
    localparam int SAMPLE_BITS = 16;
    localparam int SLOT_BITS   = $clog2(WINDOW_MAX);
    localparam int LEN_BITS    = SLOT_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS + SLOT_BITS - 1;
    localparam int LIM_BITS    = 15;
    localparam int CFG_BITS    = 15;
    localparam int IDX_BITS    = 2;
    localparam int AXES        = 3;

    localparam logic [IDX_BITS-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_MEAN_LIMIT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_STD_LIMIT  = 2'd2;

    localparam logic [9:0] RST_WINDOW_LEN = 10'd500;
    localparam logic [LIM_BITS-1:0] RST_MEAN_LIMIT = 15'd300;
    localparam logic [LIM_BITS-1:0] RST_STD_LIMIT  = 15'd100;

    // Per-lane control from the sequencer.
    typedef struct packed {
        logic clear;
        logic update;
        logic remove_old;
        logic test;
        logic divide_start;
    } lane_ctrl_t;

    // Per-lane verdict to the merge stage.
    typedef struct packed {
        logic mean_ok;
        logic var_ok;
    } lane_stat_t;

endpackage

@@ rtl/core/fwzd_divider.sv @@
// Restoring divider: signed sum over unsigned window length, truncated toward
// zero, one quotient bit per cycle. Uses fwzd_pkg.
module fwzd_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [fwzd_pkg::SUM_BITS-1:0] dividend,
    input  logic [fwzd_pkg::LEN_BITS-1:0] divisor,
    output logic                          busy,
    output logic signed [fwzd_pkg::SAMPLE_BITS-1:0] quotient
);
    import fwzd_pkg::*;

    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic [SUM_BITS-1:0] num_reg, num_next;
    logic [SUM_BITS-1:0] rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic                busy_reg, busy_next;
    logic [LEN_BITS-1:0] den_reg, den_next;
    logic [SUM_BITS:0]   trial;
    logic [SUM_BITS-1:0] q_signed;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        den_next  = den_reg;
        trial     = '0;
        if (start)
        begin
            neg_next  = dividend[SUM_BITS-1];
            num_next  = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_BITS'(SUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract if it fits
            trial = {rem_reg, num_reg[SUM_BITS-1]} - (SUM_BITS+1)'(den_reg);
            if (!trial[SUM_BITS])
            begin
                rem_next = trial[SUM_BITS-1:0];
                num_next = {num_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[SUM_BITS-2:0], num_reg[SUM_BITS-1]};
                num_next = {num_reg[SUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        den_reg <= den_next;
    end

    assign q_signed = neg_reg ? SUM_BITS'(-num_reg) : num_reg;
    assign quotient = q_signed[SAMPLE_BITS-1:0];
    assign busy     = busy_reg;

endmodule

@@ rtl/core/fwzd_lane.sv @@
// One axis lane: running sum and sum of squares, stability tests, mean divide.
// Uses fwzd_pkg and fwzd_divider.
module fwzd_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fwzd_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [fwzd_pkg::SAMPLE_BITS-1:0] new_smp,
    input  logic signed [fwzd_pkg::SAMPLE_BITS-1:0] old_smp,
    input  logic [fwzd_pkg::LEN_BITS-1:0]        win_len,
    input  logic [2*fwzd_pkg::SUM_BITS-1:0]      mean_bound,
    input  logic [2*fwzd_pkg::SUM_BITS+1:0]      std_bound,
    output fwzd_pkg::lane_stat_t                 stat,
    output logic                                 div_busy,
    output logic signed [fwzd_pkg::SAMPLE_BITS-1:0] mean
);
    import fwzd_pkg::*;

    localparam int PROD_BITS = SQ_BITS + LEN_BITS;

    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [SQ_BITS-1:0]         sq_reg, sq_next;
    logic [2*SAMPLE_BITS-1:0]   new_sq_reg, old_sq_reg;
    logic [SUM_BITS-1:0]        mag;
    logic [PROD_BITS-1:0]       nsq_reg;
    logic [2*SUM_BITS-1:0]      mag_sq_reg;
    logic [SUM_BITS-1:0]        mag_reg;
    logic [PROD_BITS:0]         var_num;

    // square both samples ahead of the update
    always_ff @(posedge clk)
    begin
        new_sq_reg <= (2*SAMPLE_BITS)'(new_smp * new_smp);
        old_sq_reg <= (2*SAMPLE_BITS)'(old_smp * old_smp);
    end

    always_comb
    begin
        sum_next = sum_reg;
        sq_next  = sq_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
            sq_next  = '0;
        end
        else if (ctrl.update)
        begin
            if (ctrl.remove_old)
            begin
                sum_next = sum_reg + SUM_BITS'(new_smp) - SUM_BITS'(old_smp);
                sq_next  = sq_reg + SQ_BITS'(new_sq_reg) - SQ_BITS'(old_sq_reg);
            end
            else
            begin
                sum_next = sum_reg + SUM_BITS'(new_smp);
                sq_next  = sq_reg + SQ_BITS'(new_sq_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
        end
    end

    assign mag = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : sum_reg;

    // products of the updated sums, one register stage
    always_ff @(posedge clk)
    begin
        nsq_reg    <= PROD_BITS'(sq_reg * win_len);
        mag_sq_reg <= mag * mag;
        mag_reg    <= mag;
    end

    assign var_num      = (PROD_BITS+1)'(nsq_reg) - (PROD_BITS+1)'(mag_sq_reg);
    assign stat.mean_ok = (2*SUM_BITS)'(mag_reg) <= mean_bound;
    assign stat.var_ok  = (2*SUM_BITS+2)'(var_num) <= std_bound;

    fwzd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.divide_start),
        .dividend (sum_reg),
        .divisor  (win_len),
        .busy     (div_busy),
        .quotient (mean)
    );

endmodule

@@ rtl/core/fwzd_merge.sv @@
// Merge stage: combines lane verdicts, latches offsets and the done flag.
// Uses fwzd_pkg.
module fwzd_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      test,
    input  logic                      full,
    input  logic                      latch,
    input  fwzd_pkg::lane_stat_t [2:0] stat,
    input  logic [2:0][fwzd_pkg::SAMPLE_BITS-1:0] mean,
    output logic                      stable,
    output logic                      done,
    output logic [2:0][fwzd_pkg::SAMPLE_BITS-1:0] offset
);
    import fwzd_pkg::*;

    logic stable_reg, done_reg;
    logic [2:0][SAMPLE_BITS-1:0] offset_reg;
    logic all_ok;

    always_comb
    begin
        all_ok = 1'b1;
        for (int a = 0; a < AXES; a++)
            all_ok = all_ok & stat[a].mean_ok & stat[a].var_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            done_reg   <= 1'b0;
            offset_reg <= '0;
        end
        else
        begin
            if (test)
            begin
                stable_reg <= full & all_ok;
                if (full & all_ok)
                    done_reg <= 1'b1;
            end
            if (latch)
                offset_reg <= mean;
        end
    end

    assign stable = stable_reg;
    assign done   = done_reg;
    assign offset = offset_reg;

endmodule

@@ rtl/core/force_window_zero_detector_top.sv @@
// Top level of the force window zero detector: ring memory, sequencer, three
// axis lanes and the merge stage. Uses fwzd_pkg, fwzd_lane, fwzd_merge.
//
// Usage: s_tdata carries one request {force_z, force_y, force_x}, x lowest.
// m_tdata returns {offset_z, offset_y, offset_x, zero_done, stable_now,
// window_full} with window_full at bit 0, one result per request.
// A result passes the steps read ring, square, update sums, products, compare
// and output when the window is not stable; when it is stable the offsets
// come from a per-lane restoring divider, one quotient bit a cycle, plus the
// latch, before the output step.
// The result sits in an output register; the next request is taken in the
// cycle that result is handed off, or later, once the sequencer is idle.
// A stall on m_tready holds that register and, through s_tready, the input.
// Reset empties the window, zeroes offsets and done, loads default limits.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong between requests while idle; a write to window_len empties the window.
module force_window_zero_detector_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // force_x, force_y, force_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // window_full, stable_now, zero_done,
                                   // offset_x, offset_y, offset_z, zero fill
    input  logic        cfg_we,
    input  logic [fwzd_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [fwzd_pkg::CFG_BITS-1:0] cfg_data
);
    import fwzd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_SQUARE, ST_UPDATE, ST_PROD, ST_TEST, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;
    logic [9:0]          win_cfg_reg;
    logic [LIM_BITS-1:0] mean_lim_reg, std_lim_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [LEN_BITS-1:0]  fill_reg;
    logic [LEN_BITS-1:0]  n_eff;
    logic [3*SAMPLE_BITS-1:0] smp_reg;
    logic [3*SAMPLE_BITS-1:0] ring [WINDOW_MAX];
    logic [3*SAMPLE_BITS-1:0] old_reg;
    logic                remove_reg, full_reg;
    logic                out_valid_reg;
    logic [55:0]         out_data_reg;
    logic [2*SUM_BITS-1:0] mean_bound;
    logic [2*SUM_BITS+1:0] std_bound;
    logic [2*LIM_BITS-1:0] std_sq_reg;
    logic [2*LEN_BITS-1:0] n_sq_reg;
    logic [SLOT_BITS-1:0]  old_slot;
    lane_ctrl_t          ctrl;
    lane_stat_t [2:0]    stat;
    logic [2:0]          busy;
    logic [2:0][SAMPLE_BITS-1:0] mean, offset;
    logic                stable, done, latch_reg, cfg_clear;
    logic                accept;
    logic                all_ok;

    assign n_eff = (win_cfg_reg == '0) ? LEN_BITS'(1) :
                   (win_cfg_reg > 10'(WINDOW_MAX)) ? LEN_BITS'(WINDOW_MAX) :
                   LEN_BITS'(win_cfg_reg);
    assign old_slot  = slot_reg - n_eff[SLOT_BITS-1:0];
    assign accept    = s_tvalid & s_tready;
    assign s_tready  = (state_reg == ST_IDLE) & (~out_valid_reg | m_tready);
    assign cfg_clear = cfg_we & (cfg_index == REG_WINDOW_LEN);
    assign all_ok    = stat[0].mean_ok & stat[0].var_ok & stat[1].mean_ok &
                       stat[1].var_ok & stat[2].mean_ok & stat[2].var_ok;

    // limit products follow the limit registers; std_bound via std_sq_reg/n_sq_reg
    always_ff @(posedge clk)
    begin
        std_sq_reg <= std_lim_reg * std_lim_reg;
        n_sq_reg   <= n_eff * n_eff;
        std_bound  <= (2*SUM_BITS+2)'(std_sq_reg * n_sq_reg);
        mean_bound <= (2*SUM_BITS)'(mean_lim_reg * n_eff);
    end

    // read the oldest sample at acceptance, before its slot can be overwritten
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring[slot_reg] <= s_tdata;
            old_reg        <= ring[old_slot];
        end
    end

    always_comb
    begin
        ctrl              = '0;
        ctrl.clear        = cfg_clear;
        ctrl.update       = (state_reg == ST_UPDATE);
        ctrl.remove_old   = remove_reg;
        ctrl.divide_start = (state_reg == ST_TEST) & full_reg & all_ok;
        ctrl.test         = (state_reg == ST_TEST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_cfg_reg   <= RST_WINDOW_LEN;
            mean_lim_reg  <= RST_MEAN_LIMIT;
            std_lim_reg   <= RST_STD_LIMIT;
            slot_reg      <= '0;
            fill_reg      <= '0;
            remove_reg    <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            latch_reg     <= 1'b0;
        end
        else
        begin
            latch_reg <= 1'b0;
            if (out_valid_reg & m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_LEN:
                    begin
                        win_cfg_reg <= cfg_data[9:0];
                        slot_reg    <= '0;
                        fill_reg    <= '0;
                    end
                    REG_MEAN_LIMIT: mean_lim_reg <= cfg_data[LIM_BITS-1:0];
                    REG_STD_LIMIT:  std_lim_reg  <= cfg_data[LIM_BITS-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        remove_reg <= (fill_reg >= n_eff);
                        full_reg   <= (fill_reg >= n_eff) | (fill_reg + 1'b1 == n_eff);
                        if (fill_reg < n_eff)
                            fill_reg <= fill_reg + 1'b1;
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                ST_READ:   state_reg <= ST_SQUARE;
                ST_SQUARE: state_reg <= ST_UPDATE;
                ST_UPDATE: state_reg <= ST_PROD;
                ST_PROD:   state_reg <= ST_TEST;
                ST_TEST:   state_reg <= (full_reg & all_ok) ? ST_DIV : ST_OUT;
                ST_DIV:
                    if (busy == 3'b000)
                    begin
                        latch_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                ST_OUT:
                    if (!latch_reg && (!out_valid_reg || m_tready))
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            smp_reg <= s_tdata;
        if (state_reg == ST_OUT)
            out_data_reg <= {5'd0, offset[2], offset[1], offset[0],
                             done, stable & full_reg, full_reg};
    end

    // lane verdicts are valid in ST_TEST; the merge registers them there and
    // stable holds the verdict from ST_DIV or ST_OUT on
    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        fwzd_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_smp    (smp_reg[a*SAMPLE_BITS +: SAMPLE_BITS]),
            .old_smp    (old_reg[a*SAMPLE_BITS +: SAMPLE_BITS]),
            .win_len    (n_eff),
            .mean_bound (mean_bound),
            .std_bound  (std_bound),
            .stat       (stat[a]),
            .div_busy   (busy[a]),
            .mean       (mean[a])
        );
    end

    fwzd_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .test   (state_reg == ST_TEST),
        .full   (full_reg),
        .latch  (latch_reg),
        .stat   (stat),
        .mean   (mean),
        .stable (stable),
        .done   (done),
        .offset (offset)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LEN_BITS'(WINDOW_MAX))
        else $error("fill count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_div_only_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> full_reg)
        else $error("divide without full window");
`endif

endmodule
